>>> rtl/bov_pkg.sv
// ----------------------------------------------------------------------------
// bov_pkg: shared types and constants for the box outline overlay
// Register indexes, channel payloads, queue entry and fixed constants.
// ----------------------------------------------------------------------------
package bov_pkg;

  // Configuration channel widths
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Cycles from a register write until the derived box geometry is settled
  localparam int unsigned GEO_LAT = 4;

  // Entries in the queue between classifier and writer
  localparam int unsigned Q_DEPTH = 2;

  // floor(s / 3) == (s * MEAN_MUL) >> MEAN_SHIFT for every s up to 765
  localparam int unsigned MEAN_MUL   = 683;
  localparam int unsigned MEAN_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_A_X   = 8'd0,
    REG_CORNER_A_Y   = 8'd1,
    REG_CORNER_B_X   = 8'd2,
    REG_CORNER_B_Y   = 8'd3,
    REG_BOX_COLOR    = 8'd4,
    REG_LINE_WIDTH   = 8'd5,
    REG_FRAME_WIDTH  = 8'd6,
    REG_FRAME_HEIGHT = 8'd7
  } reg_idx_e;

  // Input pixel
  typedef struct packed {
    logic       start_of_frame;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } pix_t;

  // Output pixel
  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic       on_box;
    logic       end_of_frame;
  } res_t;

  // Configuration register file
  typedef struct packed {
    logic signed [15:0] corner_a_x;
    logic signed [15:0] corner_a_y;
    logic signed [15:0] corner_b_x;
    logic signed [15:0] corner_b_y;
    logic [23:0]        box_color;
    logic [7:0]         line_width;
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    corner_a_x:   16'sd0,
    corner_a_y:   16'sd0,
    corner_b_x:   16'sd0,
    corner_b_y:   16'sd0,
    box_color:    24'd0,
    line_width:   8'd1,
    frame_width:  13'd640,
    frame_height: 13'd480
  };

  // Classified pixel waiting for the writer
  typedef struct packed {
    logic       hit;
    logic       eof;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } qent_t;

endpackage

>>> rtl/bov_if.sv
// ----------------------------------------------------------------------------
// bov_if: valid/ready channel interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface bov_pix_if;
  logic          valid;
  logic          ready;
  bov_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bov_res_if;
  logic          valid;
  logic          ready;
  bov_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bov_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bov_pkg::CFG_IDX_W-1:0]    index;
  logic [bov_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/box_outline_overlay_top.sv
// ----------------------------------------------------------------------------
// box_outline_overlay_top: rectangular outline overlay on a pixel stream
// Classifies raster pixels against a clamped box outline and replaces the
// pixels on its bands with the box colour, or its gray level for one channel.
//
//   Channel   Dir   Handshake       Payload
//   cfg_i     in    valid / ready   index, data (register write)
//   pix_i     in    valid / ready   start_of_frame, chan0..chan2
//   res_o     out   valid / ready   out_chan0..out_chan2, on_box, end_of_frame
//
// One pixel per clock sustained; results pass through a two-entry queue and the
// output register. After reset and after each register write, pix_i.ready stays
// low while the box geometry pipeline settles. A stalled output fills the queue,
// then drops pix_i.ready.
// ----------------------------------------------------------------------------
module box_outline_overlay_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned CHANNELS   = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bov_cfg_if.sink   cfg_i,
  bov_pix_if.sink   pix_i,
  bov_res_if.source res_o
);
  import bov_pkg::*;

  cfg_t       regs;
  logic       busy;
  logic [7:0] gray;
  logic       push, full, pop, empty;
  qent_t      ent_in, ent_out;

  bov_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs),
    .busy_o (busy),
    .gray_o (gray)
  );

  bov_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .regs_i   (regs),
    .busy_i   (busy),
    .q_full_i (full),
    .push_o   (push),
    .ent_o    (ent_in)
  );

  bov_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .ent_o   (ent_out)
  );

  bov_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ent_i   (ent_out),
    .pop_o   (pop),
    .regs_i  (regs),
    .gray_i  (gray),
    .res_o   (res_o)
  );

endmodule

>>> rtl/bov_cfg.sv
// ----------------------------------------------------------------------------
// bov_cfg: configuration register file
// Holds the box registers, derives the gray level of the box colour and
// flags the settling window after each register write.
// ----------------------------------------------------------------------------
module bov_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  bov_cfg_if.sink       cfg_i,
  output bov_pkg::cfg_t regs_o,
  output logic          busy_o,
  output logic [7:0]    gray_o
);
  import bov_pkg::*;

  localparam int unsigned CNT_W = $clog2(GEO_LAT + 1);

  cfg_t             regs_q, regs_d;
  logic [CNT_W-1:0] busy_cnt_q, busy_cnt_d;
  logic [9:0]       sum_q;
  logic [19:0]      prod_q;
  logic             wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // Decode register writes
  always_comb begin
    regs_d = regs_q;
    if (wr) begin
      case (reg_idx_e'(cfg_i.index))
        REG_CORNER_A_X:   regs_d.corner_a_x   = cfg_i.data[15:0];
        REG_CORNER_A_Y:   regs_d.corner_a_y   = cfg_i.data[15:0];
        REG_CORNER_B_X:   regs_d.corner_b_x   = cfg_i.data[15:0];
        REG_CORNER_B_Y:   regs_d.corner_b_y   = cfg_i.data[15:0];
        REG_BOX_COLOR:    regs_d.box_color    = cfg_i.data[23:0];
        REG_LINE_WIDTH:   regs_d.line_width   = cfg_i.data[7:0];
        REG_FRAME_WIDTH:  regs_d.frame_width  = cfg_i.data[12:0];
        REG_FRAME_HEIGHT: regs_d.frame_height = cfg_i.data[12:0];
        default: ;
      endcase
    end
  end

  // Reload the settling counter on every write, count down otherwise
  always_comb begin
    busy_cnt_d = busy_cnt_q;
    if (wr) begin
      busy_cnt_d = CNT_W'(GEO_LAT);
    end else if (busy_cnt_q != '0) begin
      busy_cnt_d = busy_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q     <= CFG_RESET;
      busy_cnt_q <= CNT_W'(GEO_LAT);
    end else begin
      regs_q     <= regs_d;
      busy_cnt_q <= busy_cnt_d;
    end
  end

  // Gray level: byte sum, then divide by three through a reciprocal
  always_ff @(posedge clk_i) begin
    sum_q  <= {2'b00, regs_q.box_color[7:0]} + {2'b00, regs_q.box_color[15:8]}
            + {2'b00, regs_q.box_color[23:16]};
    prod_q <= 20'(sum_q) * 20'(MEAN_MUL);
  end

  assign regs_o = regs_q;
  assign busy_o = (busy_cnt_q != '0);
  assign gray_o = prod_q[MEAN_SHIFT +: 8];

endmodule

>>> rtl/bov_front.sv
// ----------------------------------------------------------------------------
// bov_front: pixel classifier
// Tracks the raster position, derives the clamped box geometry from the
// registers and marks each accepted pixel as on or off the outline.
// ----------------------------------------------------------------------------
module bov_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned CHANNELS   = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bov_pix_if.sink        pix_i,
  input  bov_pkg::cfg_t  regs_i,
  input  logic           busy_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bov_pkg::qent_t ent_o
);
  import bov_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW = CW + 8;
  localparam int unsigned YW = RW + 8;

  // Clamp a signed corner into 0 .. lim-1
  function automatic logic [31:0] clamp_to(logic signed [15:0] v, logic [31:0] lim);
    logic [31:0] vu;
    logic [31:0] res;
    vu = {17'b0, v[14:0]};
    if (v[15]) begin
      res = '0;
    end else if (vu >= lim) begin
      res = lim - 32'd1;
    end else begin
      res = vu;
    end
    return res;
  endfunction

  // Geometry stage A: effective sizes and line width
  logic [WW-1:0] w_a_q;
  logic [HW-1:0] h_a_q;
  logic [7:0]    lw_a_q;
  // Stage B: clamped corners
  logic [CW-1:0] ax_b_q, bx_b_q;
  logic [RW-1:0] ay_b_q, by_b_q;
  // Stage C: sorted corners
  logic [CW-1:0] x1_c_q, x2_c_q;
  logic [RW-1:0] y1_c_q, y2_c_q;
  // Stage D: band ends and last positions
  logic [XW-1:0] x1e_q, x2e_q;
  logic [YW-1:0] y1e_q, y2e_q;
  logic [RW-1:0] yr_q;
  logic [CW-1:0] wm1_q;
  logic [RW-1:0] hm1_q;

  logic [31:0]   fw32, fh32;
  logic [YW-1:0] ysum, hlim;

  always_comb begin
    fw32 = 32'(regs_i.frame_width);
    fh32 = 32'(regs_i.frame_height);
    ysum = YW'(y2_c_q) + YW'(lw_a_q) - YW'(1);
    hlim = YW'(h_a_q) - YW'(1);
  end

  // Geometry pipeline, settles within the busy window after a write
  always_ff @(posedge clk_i) begin
    w_a_q  <= (fw32 == 32'd0) ? WW'(1) :
              ((fw32 > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(regs_i.frame_width));
    h_a_q  <= (fh32 == 32'd0) ? HW'(1) :
              ((fh32 > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(regs_i.frame_height));
    lw_a_q <= (regs_i.line_width == 8'd0) ? 8'd1 : regs_i.line_width;

    ax_b_q <= CW'(clamp_to(regs_i.corner_a_x, 32'(w_a_q)));
    bx_b_q <= CW'(clamp_to(regs_i.corner_b_x, 32'(w_a_q)));
    ay_b_q <= RW'(clamp_to(regs_i.corner_a_y, 32'(h_a_q)));
    by_b_q <= RW'(clamp_to(regs_i.corner_b_y, 32'(h_a_q)));

    x1_c_q <= (ax_b_q > bx_b_q) ? bx_b_q : ax_b_q;
    x2_c_q <= (ax_b_q > bx_b_q) ? ax_b_q : bx_b_q;
    y1_c_q <= (ay_b_q > by_b_q) ? by_b_q : ay_b_q;
    y2_c_q <= (ay_b_q > by_b_q) ? ay_b_q : by_b_q;

    x1e_q  <= XW'(x1_c_q) + XW'(lw_a_q);
    x2e_q  <= XW'(x2_c_q) + XW'(lw_a_q);
    y1e_q  <= YW'(y1_c_q) + YW'(lw_a_q);
    y2e_q  <= YW'(y2_c_q) + YW'(lw_a_q);
    yr_q   <= RW'((ysum > hlim) ? hlim : ysum);
    wm1_q  <= CW'(w_a_q - 1'b1);
    hm1_q  <= RW'(h_a_q - 1'b1);
  end

  // Raster position of the next pixel
  logic [CW-1:0] col_q, col_d, c;
  logic [RW-1:0] row_q, row_d, r;
  logic          accept, col_last, row_last;
  logic [XW-1:0] cx;
  logic [YW-1:0] ry;
  logic          in_x, c_lt_w, r_lt_h, band_tb, band_l, band_r, hit;

  assign pix_i.ready = !q_full_i && !busy_i;
  assign accept      = pix_i.valid && pix_i.ready;

  // Classify the current pixel against the four bands
  always_comb begin
    c        = pix_i.data.start_of_frame ? '0 : col_q;
    r        = pix_i.data.start_of_frame ? '0 : row_q;
    cx       = XW'(c);
    ry       = YW'(r);
    in_x     = (cx >= XW'(x1_c_q)) && (cx <= XW'(x2_c_q));
    c_lt_w   = cx < XW'(w_a_q);
    r_lt_h   = ry < YW'(h_a_q);
    band_tb  = in_x && r_lt_h &&
               (((ry >= YW'(y1_c_q)) && (ry < y1e_q)) ||
                ((ry >= YW'(y2_c_q)) && (ry < y2e_q)));
    band_l   = c_lt_w && (r >= y1_c_q) && (r <= y2_c_q) &&
               (c >= x1_c_q) && (cx < x1e_q);
    band_r   = c_lt_w && (r >= y1_c_q) && (r <= yr_q) &&
               (c >= x2_c_q) && (cx < x2e_q);
    hit      = ((CHANNELS == 1) || (CHANNELS == 3)) && (band_tb || band_l || band_r);
    col_last = c >= wm1_q;
    row_last = r >= hm1_q;
  end

  // Advance the position on every transfer
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : RW'(r + 1'b1);
      end else begin
        col_d = CW'(c + 1'b1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o      = accept;
  assign ent_o.hit   = hit;
  assign ent_o.eof   = col_last && row_last;
  assign ent_o.chan0 = pix_i.data.chan0;
  assign ent_o.chan1 = pix_i.data.chan1;
  assign ent_o.chan2 = pix_i.data.chan2;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !pix_i.ready)
    else $error("pixel taken while box geometry settles");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !col_last) |=> (col_q == CW'($past(c) + 1'b1)))
    else $error("column did not advance by one");

  a_eof_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_last && row_last) |=> (col_q == '0 && row_q == '0))
    else $error("position did not wrap after last pixel");

endmodule

>>> rtl/bov_queue.sv
// ----------------------------------------------------------------------------
// bov_queue: short queue of classified pixels
// Decouples the classifier from the output writer.
// ----------------------------------------------------------------------------
module bov_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bov_pkg::qent_t ent_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bov_pkg::qent_t ent_o
);
  import bov_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned NW = $clog2(Q_DEPTH + 1);

  qent_t         slot_q [Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign ent_o   = slot_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= ent_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/bov_back.sv
// ----------------------------------------------------------------------------
// bov_back: output writer
// Paints classified pixels with the box colour or its gray level and holds them
// in the output register until the sink takes them.
// ----------------------------------------------------------------------------
module bov_back #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bov_pkg::qent_t ent_i,
  output logic           pop_o,
  input  bov_pkg::cfg_t  regs_i,
  input  logic [7:0]     gray_i,
  bov_res_if.source      res_o
);
  import bov_pkg::*;

  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  // Take a new entry when the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || res_o.ready);

  // Paint the pixel and blank unused channels
  always_comb begin
    res_d.out_chan0    = ent_i.chan0;
    res_d.out_chan1    = ent_i.chan1;
    res_d.out_chan2    = ent_i.chan2;
    res_d.on_box       = ent_i.hit;
    res_d.end_of_frame = ent_i.eof;
    if (ent_i.hit) begin
      if (CHANNELS == 1) begin
        res_d.out_chan0 = gray_i;
      end else begin
        res_d.out_chan0 = regs_i.box_color[7:0];
        res_d.out_chan1 = regs_i.box_color[15:8];
        res_d.out_chan2 = regs_i.box_color[23:16];
      end
    end
    if (CHANNELS < 2) begin
      res_d.out_chan1 = 8'd0;
    end
    if (CHANNELS < 3) begin
      res_d.out_chan2 = 8'd0;
    end
  end

  // Hold the result until transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

endmodule
